>>> design/mas_pkg.sv
// Shared constants, codes and types for the matrix add, subtract and multiply engine.
package mas_pkg;

    // Field widths fixed by the interface.
    localparam int ELEM_W     = 16;
    localparam int VALUE_W    = 35;
    localparam int POS_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int DIM_REG_W  = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Default matrix size limit and result cap.
    localparam int MAX_DIM_DEF = 8;
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = 7;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOOP = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOOP = 2'd2;

    // Control of the accumulator ring for one cycle.
    typedef struct packed {
        logic clr;     // zero every cell
        logic shift;   // rotate the ring by one place
        logic drain;   // the tail takes zero instead of the head
        logic inj_en;  // add the injected term on the way to the tail
    } t_ring_ctl;

endpackage

>>> design/matrix_add_sub_multiply_top.sv
// Top level of the matrix add, subtract and multiply engine.
//
//  Channel  | Handshake                         | Payload
//  ---------+-----------------------------------+-----------------------------------
//  element  | start in, busy out                | i_element
//  config   | i_cfg_valid in, o_cfg_ready out   | i_cfg_index, i_cfg_data
//  result   | o_strobe out (no back-pressure)   | o_value, o_row, o_col, o_status, o_last
//
// Elements load at one request per cycle while busy is low. The final element starts
// a run, unless no-op or a size mismatch gives an error result in the next cycle: busy
// rises and each result row makes K accumulate passes and one drain pass of the ring
// (K = cols_a for multiply, 1 otherwise), fed through the store read and term registers.
// Reset is synchronous and active low; results cannot be stalled by the receiver.
module matrix_add_sub_multiply_top #(
    parameter int MAX_DIM = mas_pkg::MAX_DIM_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [mas_pkg::ELEM_W-1:0]      i_element,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mas_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [mas_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic                                   o_strobe,
    output logic signed [mas_pkg::VALUE_W-1:0]     o_value,
    output logic [mas_pkg::POS_W-1:0]              o_row,
    output logic [mas_pkg::POS_W-1:0]              o_col,
    output logic [mas_pkg::STATUS_W-1:0]           o_status,
    output logic                                   o_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = 2 * DW + 1;
    localparam int MW    = IW + DW + 1;
    localparam int ACC_W = 32 + $clog2(MAX_DIM);
    localparam int TW    = 2 * DW;
    localparam int VW    = mas_pkg::VALUE_W;

    // Configuration registers.
    logic [mas_pkg::DIM_REG_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [mas_pkg::MODE_W-1:0]    r_mode;
    logic                          w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= 4'd1;
            r_cols_a <= 4'd1;
            r_rows_b <= 4'd1;
            r_cols_b <= 4'd1;
            r_mode   <= mas_pkg::MODE_ADD;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                mas_pkg::REG_ROWS_A: r_rows_a <= i_cfg_data;
                mas_pkg::REG_COLS_A: r_cols_a <= i_cfg_data;
                mas_pkg::REG_ROWS_B: r_rows_b <= i_cfg_data;
                mas_pkg::REG_COLS_B: r_cols_b <= i_cfg_data;
                mas_pkg::REG_MODE:   r_mode   <= i_cfg_data[mas_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective dimensions: zero acts as one, oversize acts as MAX_DIM.
    function automatic logic [DW-1:0] eff_dim(input logic [mas_pkg::DIM_REG_W-1:0] d);
        logic [DW-1:0] res;
        if (d == '0) begin
            res = DW'(1);
        end else if (32'(d) > MAX_DIM) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(d);
        end
        return res;
    endfunction

    logic [DW-1:0] w_ra, w_ca, w_rb, w_cb, w_cc, w_kk;
    logic          w_is_mul;

    always_comb begin
        w_ra     = eff_dim(r_rows_a);
        w_ca     = eff_dim(r_cols_a);
        w_rb     = eff_dim(r_rows_b);
        w_cb     = eff_dim(r_cols_b);
        w_is_mul = (r_mode == mas_pkg::MODE_MUL);
        w_cc     = w_is_mul ? w_cb : w_ca;
        w_kk     = w_is_mul ? w_ca : DW'(1);
    end

    // Loader: place each element in A or B and spot the final one.
    logic [CW-1:0] r_load_cnt;
    logic [CW-1:0] w_na, w_nb, w_pos_b;
    logic          w_accept, w_we_a, w_we_b, w_final, w_size_err, w_noop;
    logic          r_run;

    assign busy     = r_run;
    assign w_accept = start && !busy;

    always_comb begin
        w_na       = CW'(w_ra) * CW'(w_ca);
        w_nb       = CW'(w_rb) * CW'(w_cb);
        w_pos_b    = r_load_cnt - w_na;
        w_we_a     = w_accept && (r_load_cnt < w_na);
        w_we_b     = w_accept && !(r_load_cnt < w_na) && (w_pos_b < w_nb);
        w_final    = (r_load_cnt + CW'(1)) >= (w_na + w_nb);
        w_noop     = (r_mode == mas_pkg::MODE_NOOP);
        w_size_err = w_is_mul ? (w_ca != w_rb) : ((w_ra != w_rb) || (w_ca != w_cb));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (w_accept) begin
            r_load_cnt <= w_final ? '0 : (r_load_cnt + CW'(1));
        end
    end

    // Sequencer: rows, then K accumulate passes and one drain pass of MAX_DIM steps.
    logic          r_seq;
    logic [IW-1:0] r_i, r_k, r_j;
    logic          r_out;
    logic          w_run_start, w_emit, w_emit_last, w_j_wrap;

    assign w_run_start = w_accept && w_final && !w_noop && !w_size_err;
    assign w_j_wrap    = (r_j == IW'(MAX_DIM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= 1'b0;
            r_i   <= '0;
            r_k   <= '0;
            r_j   <= '0;
            r_out <= 1'b0;
        end else if (w_run_start) begin
            r_seq <= 1'b1;
            r_i   <= '0;
            r_k   <= '0;
            r_j   <= '0;
            r_out <= 1'b0;
        end else if (w_emit && w_emit_last) begin
            r_seq <= 1'b0;
        end else if (r_seq) begin
            r_j <= w_j_wrap ? '0 : (r_j + IW'(1));
            if (w_j_wrap) begin
                if (r_out) begin
                    r_out <= 1'b0;
                    r_k   <= '0;
                    r_i   <= r_i + IW'(1);
                    if (DW'(r_i) == (w_ra - DW'(1))) begin
                        r_seq <= 1'b0;
                    end
                end else if (DW'(r_k) == (w_kk - DW'(1))) begin
                    r_out <= 1'b1;
                    r_k   <= '0;
                end else begin
                    r_k <= r_k + IW'(1);
                end
            end
        end
    end

    // Read addresses for the current step.
    logic          w_in_range;
    logic [MW-1:0] w_addr_a_full, w_addr_b_full;
    logic [AW-1:0] w_raddr_a, w_raddr_b;

    always_comb begin
        w_in_range = (DW'(r_j) < w_cc);
        if (w_is_mul) begin
            w_addr_a_full = MW'(r_i) * MW'(w_ca) + MW'(r_k);
            w_addr_b_full = MW'(r_k) * MW'(w_cb) + MW'(r_j);
        end else begin
            w_addr_a_full = MW'(r_i) * MW'(w_ca) + MW'(r_j);
            w_addr_b_full = w_addr_a_full;
        end
        w_raddr_a = w_in_range ? w_addr_a_full[AW-1:0] : '0;
        w_raddr_b = w_in_range ? w_addr_b_full[AW-1:0] : '0;
    end

    logic [mas_pkg::ELEM_W-1:0] w_a_data, w_b_data;

    mas_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_load_cnt[AW-1:0]),
        .i_wdata (i_element),
        .i_raddr (w_raddr_a),
        .o_rdata (w_a_data)
    );

    mas_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_pos_b[AW-1:0]),
        .i_wdata (i_element),
        .i_raddr (w_raddr_b),
        .o_rdata (w_b_data)
    );

    // Pipeline control: stage 1 meets the read data, stage 2 the registered term.
    logic          r_s1_valid, r_s1_out, r_s1_rng;
    logic [IW-1:0] r_s1_i, r_s1_j;
    logic          r_s2_valid, r_s2_out, r_s2_rng;
    logic [IW-1:0] r_s2_i, r_s2_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_run_start || (w_emit && w_emit_last)) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_seq;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_out <= r_out;
        r_s1_rng <= w_in_range;
        r_s1_i   <= r_i;
        r_s1_j   <= r_j;
        r_s2_out <= r_s1_out;
        r_s2_rng <= r_s1_rng;
        r_s2_i   <= r_s1_i;
        r_s2_j   <= r_s1_j;
    end

    // Term stage: a product for multiply, a scaled sum or difference otherwise.
    logic signed [ACC_W-1:0]          r_term;
    logic signed [ACC_W-1:0]          n_term;
    logic signed [2*mas_pkg::ELEM_W-1:0] w_prod;
    logic signed [mas_pkg::ELEM_W:0]  w_sum;

    always_comb begin
        w_prod = $signed(w_a_data) * $signed(w_b_data);
        if (r_mode == mas_pkg::MODE_SUB) begin
            w_sum = $signed({w_a_data[mas_pkg::ELEM_W-1], w_a_data})
                  - $signed({w_b_data[mas_pkg::ELEM_W-1], w_b_data});
        end else begin
            w_sum = $signed({w_a_data[mas_pkg::ELEM_W-1], w_a_data})
                  + $signed({w_b_data[mas_pkg::ELEM_W-1], w_b_data});
        end
        if (w_is_mul) begin
            n_term = ACC_W'(w_prod);
        end else begin
            n_term = ACC_W'($signed({w_sum, 8'b0}));
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

    // Accumulator ring.
    mas_pkg::t_ring_ctl      w_ctl;
    logic signed [ACC_W-1:0] w_head;

    always_comb begin
        w_ctl.clr    = w_run_start;
        w_ctl.shift  = r_s2_valid;
        w_ctl.drain  = r_s2_out;
        w_ctl.inj_en = !r_s2_out && r_s2_rng;
    end

    mas_ring #(.N(MAX_DIM), .ACC_W(ACC_W)) u_ring (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_inj  (r_term),
        .o_head (w_head)
    );

    // Result count and cap.
    logic [TW-1:0]               r_total;
    logic [mas_pkg::RES_CNT_W-1:0] r_n;
    logic [TW-1:0]               w_total_raw;

    always_comb begin
        w_total_raw = TW'(w_ra) * TW'(w_cc);
        w_emit      = r_s2_valid && r_s2_out && r_s2_rng;
        w_emit_last = ((32'(r_n) + 1) == 32'(r_total));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_n     <= '0;
            r_total <= '0;
        end else if (w_run_start) begin
            r_run   <= 1'b1;
            r_n     <= '0;
            r_total <= (32'(w_total_raw) > mas_pkg::MAX_RESULTS)
                     ? TW'(mas_pkg::MAX_RESULTS) : w_total_raw;
        end else if (w_emit) begin
            r_n <= r_n + mas_pkg::RES_CNT_W'(1);
            if (w_emit_last) begin
                r_run <= 1'b0;
            end
        end
    end

    // Head value brought to the 35-bit result range.
    logic signed [VW-1:0] w_value;

    if (ACC_W > VW) begin : g_sat
        localparam logic signed [ACC_W-1:0] VMAX =
            {{(ACC_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
        localparam logic signed [ACC_W-1:0] VMIN =
            {{(ACC_W - VW + 1){1'b1}}, {(VW - 1){1'b0}}};
        always_comb begin
            if (w_head > VMAX) begin
                w_value = VMAX[VW-1:0];
            end else if (w_head < VMIN) begin
                w_value = VMIN[VW-1:0];
            end else begin
                w_value = w_head[VW-1:0];
            end
        end
    end else if (ACC_W == VW) begin : g_same
        assign w_value = w_head;
    end else begin : g_ext
        assign w_value = {{(VW - ACC_W){w_head[ACC_W-1]}}, w_head};
    end

    // Position fields keep their low three bits.
    logic [IW+mas_pkg::POS_W-1:0] w_row_ext, w_col_ext;

    assign w_row_ext = {{mas_pkg::POS_W{1'b0}}, r_s2_i};
    assign w_col_ext = {{mas_pkg::POS_W{1'b0}}, r_s2_j};

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_emit || (w_accept && w_final && (w_noop || w_size_err));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_value  <= w_value;
            o_row    <= w_row_ext[mas_pkg::POS_W-1:0];
            o_col    <= w_col_ext[mas_pkg::POS_W-1:0];
            o_status <= mas_pkg::ST_OK;
            o_last   <= w_emit_last;
        end else begin
            o_value  <= '0;
            o_row    <= '0;
            o_col    <= '0;
            o_status <= w_noop ? mas_pkg::ST_NOOP : mas_pkg::ST_SIZE;
            o_last   <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    // Error results always carry the last flag.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != mas_pkg::ST_OK) |-> o_last)
        else $error("error result without last");

    // The engine is free again by the time the final result shows.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy still high on the final result");

    // Good results only come out of a run.
    a_ok_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == mas_pkg::ST_OK) |-> $past(r_run))
        else $error("ok result outside a run");

    // A drain step never adds a term.
    a_drain_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.drain && w_ctl.shift |-> !w_ctl.inj_en)
        else $error("term injected during drain");
`endif

endmodule

>>> design/mas_store.sv
// Element store: one write port and one registered read port.
module mas_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [mas_pkg::ELEM_W-1:0]     i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [mas_pkg::ELEM_W-1:0]     o_rdata
);

    logic [mas_pkg::ELEM_W-1:0] r_mem [DEPTH];
    logic [mas_pkg::ELEM_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mas_cell.sv
// One accumulator cell of the ring: takes its neighbour's value, optionally plus a term.
module mas_cell #(
    parameter int ACC_W = 35
) (
    input  logic                    i_clk,
    input  logic                    i_clr,
    input  logic                    i_shift,
    input  logic signed [ACC_W-1:0] i_d,
    input  logic                    i_inj_en,
    input  logic signed [ACC_W-1:0] i_inj,
    output logic signed [ACC_W-1:0] o_q
);

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    // Next value: clear, take the neighbour's value (plus the term), or hold.
    always_comb begin
        n_acc = r_acc;
        if (i_clr) begin
            n_acc = '0;
        end else if (i_shift) begin
            n_acc = i_inj_en ? (i_d + i_inj) : i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_q = r_acc;

endmodule

>>> design/mas_ring.sv
// Ring of accumulator cells; the head holds the column due at the current step.
module mas_ring #(
    parameter int N     = 8,
    parameter int ACC_W = 35
) (
    input  logic                    i_clk,
    input  mas_pkg::t_ring_ctl      i_ctl,
    input  logic signed [ACC_W-1:0] i_inj,
    output logic signed [ACC_W-1:0] o_head
);

    logic signed [ACC_W-1:0] w_q [N];
    logic signed [ACC_W-1:0] w_d [N];
    logic                    w_inj_en [N];

    // Each cell takes from the next; the tail takes from the head or zero.
    always_comb begin
        for (int c = 0; c < N; c++) begin
            if (c == N - 1) begin
                w_d[c]      = i_ctl.drain ? '0 : w_q[0];
                w_inj_en[c] = i_ctl.inj_en;
            end else begin
                w_d[c]      = w_q[c + 1];
                w_inj_en[c] = 1'b0;
            end
        end
    end

    for (genvar c = 0; c < N; c++) begin : g_cell
        mas_cell #(.ACC_W(ACC_W)) u_cell (
            .i_clk    (i_clk),
            .i_clr    (i_ctl.clr),
            .i_shift  (i_ctl.shift),
            .i_d      (w_d[c]),
            .i_inj_en (w_inj_en[c]),
            .i_inj    (i_inj),
            .o_q      (w_q[c])
        );
    end

    assign o_head = w_q[0];

endmodule
